// ===== src/sirt_pkg.sv =====
`timescale 1ns / 1ps

package sirt_pkg;

    localparam int VALUE_W    = 64;
    localparam int RADIX_W    = 5;
    localparam int CHAR_W     = 7;
    localparam int DIGIT_W    = 4;
    localparam int NIBBLES    = VALUE_W / DIGIT_W;
    localparam int STEP_W     = $clog2(NIBBLES);
    localparam int MAX_DIGITS = 64;
    localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN    = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX    = RADIX_W'(16);
    localparam logic [RADIX_W-1:0] RADIX_HEX    = RADIX_W'(16);
    localparam logic [CHAR_W-1:0]  CHAR_ZERO    = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = CHAR_W'(8'h61);
    localparam logic [CHAR_W-1:0]  CHAR_MINUS   = CHAR_W'(8'h2d);
    localparam logic [CHAR_W-1:0]  CHAR_NONE    = CHAR_W'(0);
    localparam logic [CHAR_W-1:0]  CASE_SHIFT   = CHAR_W'(32);
    localparam logic [DIGIT_W-1:0] DECIMAL_TOP  = DIGIT_W'(10);

    typedef struct packed {
        logic start;
        logic resume;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
        logic quot_zero;
    } div_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] c;
        begin
            if (d < DECIMAL_TOP)
            begin
                c = CHAR_ZERO + CHAR_W'(d);
            end
            else
            begin
                c = CHAR_LOWER_A + CHAR_W'(d - DECIMAL_TOP);
                if (upper)
                begin
                    c = c - CASE_SHIFT;
                end
            end
            return c;
        end
    endfunction

endpackage

// ===== src/sirt_if.sv =====
`timescale 1ns / 1ps

interface sirt_num_if;
    logic                                valid;
    logic                                ready;
    logic signed [sirt_pkg::VALUE_W-1:0] value;
    logic        [sirt_pkg::RADIX_W-1:0] radix;
    logic                                upper_case;

    modport source (output valid, value, radix, upper_case, input ready);
    modport sink   (input valid, value, radix, upper_case, output ready);
endinterface

interface sirt_text_if;
    logic                         valid;
    logic                         ready;
    logic [sirt_pkg::CHAR_W-1:0]  character;
    logic                         last;
    logic                         error;

    modport source (output valid, character, last, error, input ready);
    modport sink   (input valid, character, last, error, output ready);
endinterface

// ===== src/sirt_divider.sv =====
`timescale 1ns / 1ps

module sirt_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sirt_pkg::div_ctrl_t           ctrl,
    input  logic [sirt_pkg::VALUE_W-1:0]  dividend,
    input  logic [sirt_pkg::RADIX_W-1:0]  radix,
    output sirt_pkg::div_stat_t           stat,
    output logic [sirt_pkg::DIGIT_W-1:0]  remainder
);

    logic [sirt_pkg::VALUE_W-1:0] dvd_reg, dvd_next;
    logic [sirt_pkg::RADIX_W-1:0] radix_reg, radix_next;
    logic [sirt_pkg::DIGIT_W-1:0] rem_reg, rem_next;
    logic [sirt_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic                         qnz_reg, qnz_next;
    logic [sirt_pkg::DIGIT_W:0]   r;
    logic [sirt_pkg::DIGIT_W-1:0] q;

    // one nibble of long division: four restoring steps
    always_comb
    begin
        r = {1'b0, rem_reg};
        q = '0;
        for (int k = sirt_pkg::DIGIT_W - 1; k >= 0; k--)
        begin
            r = {r[sirt_pkg::DIGIT_W-1:0], dvd_reg[sirt_pkg::VALUE_W - sirt_pkg::DIGIT_W + k]};
            if (r >= radix_reg)
            begin
                r    = r - radix_reg;
                q[k] = 1'b1;
            end
        end
    end

    always_comb
    begin
        dvd_next   = dvd_reg;
        radix_next = radix_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        qnz_next   = qnz_reg;
        if (ctrl.start || ctrl.resume)
        begin
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            qnz_next  = 1'b0;
            if (ctrl.start)
            begin
                dvd_next   = dividend;
                radix_next = radix;
            end
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[sirt_pkg::VALUE_W-sirt_pkg::DIGIT_W-1:0], q};
            rem_next = r[sirt_pkg::DIGIT_W-1:0];
            qnz_next = qnz_reg | (|q);
            cnt_next = cnt_reg + sirt_pkg::STEP_W'(1);
            if (cnt_reg == sirt_pkg::STEP_W'(sirt_pkg::NIBBLES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg   <= dvd_next;
        radix_reg <= radix_next;
        rem_reg   <= rem_next;
        qnz_reg   <= qnz_next;
    end

    assign stat.done      = done_reg;
    assign stat.quot_zero = ~qnz_reg;
    assign remainder      = rem_reg;

endmodule

// ===== src/sirt_digit_stack.sv =====
`timescale 1ns / 1ps

module sirt_digit_stack (
    input  logic                          clk,
    input  logic                          push,
    input  logic                          pop,
    input  logic [sirt_pkg::DIGIT_W-1:0]  din,
    output logic [sirt_pkg::DIGIT_W-1:0]  top
);

    logic [sirt_pkg::DIGIT_W-1:0] slot_reg  [sirt_pkg::MAX_DIGITS];
    logic [sirt_pkg::DIGIT_W-1:0] slot_next [sirt_pkg::MAX_DIGITS];

    // push shifts up, pop shifts down; the newest digit sits in slot zero
    always_comb
    begin
        for (int i = 0; i < sirt_pkg::MAX_DIGITS; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        if (push)
        begin
            slot_next[0] = din;
            for (int i = 1; i < sirt_pkg::MAX_DIGITS; i++)
            begin
                slot_next[i] = slot_reg[i-1];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < sirt_pkg::MAX_DIGITS - 1; i++)
            begin
                slot_next[i] = slot_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < sirt_pkg::MAX_DIGITS; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    assign top = slot_reg[0];

endmodule

// ===== src/signed_integer_to_radix_text.sv =====
`timescale 1ns / 1ps
// channel  dir  words                                  payload
// number   in   one per value                          value[63:0] radix[4:0] upper_case
// text     out  one character each, last on the final  character[6:0] last error
//
// A value is taken only when the previous one has been fully handed to the
// output register. Each digit takes one pass of the nibble-serial divider
// (16 nibble steps plus hand-over), so a value is ready once all its digits
// are on the stack, then leaves at one character a cycle while text.ready
// is high. Rejected inputs give one error word, set up in the emit state.
// Reset clears all control state; a stalled output holds its word.

module signed_integer_to_radix_text (
    input  logic        clk,
    input  logic        rst_n,
    sirt_num_if.sink    number,
    sirt_text_if.source text
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    logic [sirt_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                          sign_reg, sign_next;
    logic                          fail_reg, fail_next;
    logic                          upper_reg, upper_next;
    logic                          out_valid_reg, out_valid_next;
    logic [sirt_pkg::CHAR_W-1:0]   char_reg, char_next;
    logic                          last_reg, last_next;
    logic                          err_reg, err_next;

    logic                          accept;
    logic                          neg;
    logic                          bad;
    logic [sirt_pkg::VALUE_W-1:0]  raw;
    logic [sirt_pkg::VALUE_W-1:0]  mag;
    logic                          load;
    logic                          pop;
    logic [sirt_pkg::DIGIT_W-1:0]  digit;
    logic [sirt_pkg::DIGIT_W-1:0]  top_digit;
    sirt_pkg::div_ctrl_t           div_ctrl;
    sirt_pkg::div_stat_t           div_stat;

    assign number.ready = (state_reg == ST_IDLE);
    assign accept       = number.valid && number.ready;
    assign raw          = number.value;
    assign neg          = raw[sirt_pkg::VALUE_W-1];
    assign mag          = neg ? (~raw + sirt_pkg::VALUE_W'(1)) : raw;
    assign bad          = (number.radix < sirt_pkg::RADIX_MIN)
                       || (number.radix > sirt_pkg::RADIX_MAX)
                       || (raw == {1'b1, {(sirt_pkg::VALUE_W-1){1'b0}}})
                       || (neg && (number.radix == sirt_pkg::RADIX_HEX));

    assign load = !out_valid_reg || text.ready;
    assign pop  = (state_reg == ST_EMIT) && load && !fail_reg && !sign_reg;

    always_comb
    begin
        div_ctrl.start  = accept && !bad;
        div_ctrl.resume = (state_reg == ST_DIVIDE) && div_stat.done && !div_stat.quot_zero
                       && (count_reg != sirt_pkg::COUNT_W'(sirt_pkg::MAX_DIGITS - 1));
    end

    sirt_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (mag),
        .radix     (number.radix),
        .stat      (div_stat),
        .remainder (digit)
    );

    sirt_digit_stack u_stack (
        .clk  (clk),
        .push (div_stat.done),
        .pop  (pop),
        .din  (digit),
        .top  (top_digit)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sign_next      = sign_reg;
        fail_next      = fail_reg;
        upper_next     = upper_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        err_next       = err_reg;
        if (load)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = '0;
                    upper_next = number.upper_case;
                    fail_next  = bad;
                    sign_next  = neg && !bad;
                    state_next = bad ? ST_EMIT : ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    count_next = count_reg + sirt_pkg::COUNT_W'(1);
                    if (!div_ctrl.resume)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    if (fail_reg)
                    begin
                        char_next  = sirt_pkg::CHAR_NONE;
                        last_next  = 1'b1;
                        err_next   = 1'b1;
                        fail_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else if (sign_reg)
                    begin
                        char_next = sirt_pkg::CHAR_MINUS;
                        last_next = 1'b0;
                        err_next  = 1'b0;
                        sign_next = 1'b0;
                    end
                    else
                    begin
                        char_next  = sirt_pkg::digit_char(top_digit, upper_reg);
                        last_next  = (count_reg == sirt_pkg::COUNT_W'(1));
                        err_next   = 1'b0;
                        count_next = count_reg - sirt_pkg::COUNT_W'(1);
                        if (count_reg == sirt_pkg::COUNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sign_reg      <= 1'b0;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sign_reg      <= sign_next;
            fail_reg      <= fail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        upper_reg <= upper_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        err_reg   <= err_next;
    end

    assign text.valid     = out_valid_reg;
    assign text.character = char_reg;
    assign text.last      = last_reg;
    assign text.error     = err_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sirt_pkg::COUNT_W'(sirt_pkg::MAX_DIGITS))
        else $error("digit count beyond stack depth");

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside divide state");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (count_reg < sirt_pkg::COUNT_W'(sirt_pkg::MAX_DIGITS)))
        else $error("digit pushed onto full stack");

    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && err_reg) |-> (last_reg && (char_reg == sirt_pkg::CHAR_NONE)))
        else $error("error word not final or not blank");
`endif

endmodule
